FILE: rtl/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W = 9;
  localparam int OFF_W = 17;
  localparam int SYMBOL_W = 8;
  localparam int CFG_W = 16;
  localparam int REG_INDEX_W = 2;

  // bytes 0..8 are held, the tenth closes the record
  localparam int RECORD_HELD = 9;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_HELD);

  localparam int MIN_ZONE_W = 3;
  localparam int MIN_ZONE_H = 3;

  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_ZONE_COUNT = 2'd2;

  // record after delta undo, before the checks
  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic last;
  } zone_stage_t;

endpackage

FILE: rtl/lz_zone_record_decoder_top.sv
`timescale 1ns / 1ps

// copy-zone record decoder
// symbol channel: one decoded byte per request (symbol_valid / symbol_stall), ten
// bytes per record: source x, source y, destination x, destination y (each low
// byte first), then coded width and coded height.
// zone channel: one result per record (zone_valid / zone_stall) carrying the
// destination after delta undo, signed source offsets, size, bad and last_zone.
// configuration: write_enable, reg_index and write_data, registered at the clock edge;
// 0 image width, 1 image height, 2 zone count. write only while idle.
// throughput: one symbol per cycle while symbol_stall is low.
// result path: the delta undo is registered into the check stage at the edge
// that takes the tenth byte; the checks are registered when that stage moves on.
// stall: bytes one to nine are always taken; the tenth is held off only while
// both result stages are full and the zone side stalls.
// reset (rst, synchronous): byte position, previous destination, record count
// and the configuration registers clear, no result is pending.
module lz_zone_record_decoder_top (
  input  logic clk,
  input  logic rst,
  input  logic symbol_valid,
  output logic symbol_stall,
  input  logic [lzd_pkg::SYMBOL_W-1:0] symbol,
  output logic zone_valid,
  input  logic zone_stall,
  output logic [lzd_pkg::COORD_W-1:0] dest_x,
  output logic [lzd_pkg::COORD_W-1:0] dest_y,
  output logic signed [lzd_pkg::OFF_W-1:0] src_off_x,
  output logic signed [lzd_pkg::OFF_W-1:0] src_off_y,
  output logic [lzd_pkg::SIZE_W-1:0] zone_w,
  output logic [lzd_pkg::SIZE_W-1:0] zone_h,
  output logic bad,
  output logic last_zone,
  input  logic write_enable,
  input  logic [lzd_pkg::REG_INDEX_W-1:0] reg_index,
  input  logic [lzd_pkg::CFG_W-1:0] write_data
);
  import lzd_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] zone_count;

  logic [POS_W-1:0] byte_position;
  logic [SYMBOL_W-1:0] field_bytes [RECORD_HELD];
  logic [COORD_W-1:0] prev_dest_x;
  logic [COORD_W-1:0] prev_dest_y;
  logic [COORD_W-1:0] records_done;

  zone_stage_t stage;
  zone_stage_t stage_next;
  logic stage_valid;

  logic sym_take;
  logic record_close;
  logic stage_move;

  logic [COORD_W-1:0] coded_sx;
  logic [COORD_W-1:0] coded_sy;
  logic [COORD_W-1:0] coded_dx;
  logic [COORD_W-1:0] coded_dy;
  logic [COORD_W:0] done_plus;

  logic [COORD_W:0] src_x_end;
  logic [COORD_W:0] src_y_end;
  logic [COORD_W:0] dst_x_end;
  logic [COORD_W:0] dst_y_end;
  logic order_bad;
  logic bounds_bad;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= '0;
      image_height <= '0;
      zone_count <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_IMAGE_WIDTH:  image_width <= write_data;
        REG_IMAGE_HEIGHT: image_height <= write_data;
        REG_ZONE_COUNT:   zone_count <= write_data;
        default: ;
      endcase
    end
  end

  assign stage_move = !zone_valid || !zone_stall;
  assign symbol_stall = (byte_position == LAST_POS) && stage_valid && !stage_move;
  assign sym_take = symbol_valid && !symbol_stall;
  assign record_close = sym_take && (byte_position == LAST_POS);

  // delta undo on the closing byte
  always_comb begin
    coded_sx = {field_bytes[1], field_bytes[0]};
    coded_sy = {field_bytes[3], field_bytes[2]};
    coded_dx = {field_bytes[5], field_bytes[4]};
    coded_dy = {field_bytes[7], field_bytes[6]};
    done_plus = {1'b0, records_done} + (COORD_W+1)'(1);

    stage_next.src_x = coded_sx;
    stage_next.dst_x = (coded_dy == '0) ? coded_dx + prev_dest_x : coded_dx;
    stage_next.dst_y = coded_dy + prev_dest_y;
    stage_next.src_y = stage_next.dst_y - coded_sy;
    stage_next.width = {1'b0, field_bytes[RECORD_HELD-1]} + SIZE_W'(MIN_ZONE_W);
    stage_next.height = {1'b0, symbol} + SIZE_W'(MIN_ZONE_H);
    stage_next.last = (done_plus == {1'b0, zone_count});
  end

  always_ff @(posedge clk) begin
    if (sym_take && byte_position != LAST_POS) begin
      field_bytes[byte_position] <= symbol;
    end
    if (record_close) begin
      stage <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      prev_dest_x <= '0;
      prev_dest_y <= '0;
      records_done <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (sym_take) begin
        byte_position <= (byte_position == LAST_POS) ? '0 : byte_position + POS_W'(1);
      end
      if (record_close) begin
        stage_valid <= 1'b1;
        if (stage_next.last) begin
          prev_dest_x <= '0;
          prev_dest_y <= '0;
          records_done <= '0;
        end else begin
          prev_dest_x <= stage_next.dst_x;
          prev_dest_y <= stage_next.dst_y;
          records_done <= done_plus[COORD_W-1:0];
        end
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // ordering and bounds checks
  always_comb begin
    src_x_end = {1'b0, stage.src_x} + {{(COORD_W+1-SIZE_W){1'b0}}, stage.width};
    src_y_end = {1'b0, stage.src_y} + {{(COORD_W+1-SIZE_W){1'b0}}, stage.height};
    dst_x_end = {1'b0, stage.dst_x} + {{(COORD_W+1-SIZE_W){1'b0}}, stage.width};
    dst_y_end = {1'b0, stage.dst_y} + {{(COORD_W+1-SIZE_W){1'b0}}, stage.height};
    order_bad = (stage.src_y > stage.dst_y)
             || (stage.src_y == stage.dst_y && stage.src_x >= stage.dst_x);
    bounds_bad = (src_x_end > {1'b0, image_width}) || (src_y_end > {1'b0, image_height})
              || (dst_x_end > {1'b0, image_width}) || (dst_y_end > {1'b0, image_height});
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_move) begin
      dest_x <= stage.dst_x;
      dest_y <= stage.dst_y;
      src_off_x <= {1'b0, stage.src_x} - {1'b0, stage.dst_x};
      src_off_y <= {1'b0, stage.src_y} - {1'b0, stage.dst_y};
      zone_w <= stage.width;
      zone_h <= stage.height;
      bad <= order_bad || bounds_bad;
      last_zone <= stage.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_valid <= 1'b0;
    end else if (stage_move) begin
      zone_valid <= stage_valid;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS)
    else $error("byte position beyond record length");

  a_stall_only_on_close: assert property (@(posedge clk) disable iff (rst)
    symbol_stall |-> (byte_position == LAST_POS) && zone_valid && zone_stall)
    else $error("symbol held off while a result stage is free");

  a_close_fills_stage: assert property (@(posedge clk) disable iff (rst)
    record_close |=> stage_valid && byte_position == '0)
    else $error("closing byte did not load the check stage");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    record_close && stage_next.last |=>
      prev_dest_x == '0 && prev_dest_y == '0 && records_done == '0)
    else $error("stream state not cleared after last record");

  a_stage_to_output: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_move |=> zone_valid && last_zone == $past(stage.last))
    else $error("check stage lost on its way to the output");

endmodule
